@@ design/ndtc_pkg.sv @@
// ============================================================================
// ndtc_pkg: shared types and constants of the non-drop timecode generator
// Holds the command codes, register indexes, the divider and sequencer
// interface structs and the frame rate clamp used across the design.
// ============================================================================
package ndtc_pkg;

  localparam int POS_W          = 48;   // frame position width
  localparam int LEN_W          = 48;   // length limit register width
  localparam int SEEK_W         = 48;   // seek position field width
  localparam int RATE_W         = 7;    // frame rate register width
  localparam int START_W        = 24;   // start frames register width
  localparam int DAY_W          = 24;   // holds one day of frames at the top rate
  localparam int CFG_W          = 48;   // widest configuration register
  localparam int STEP_W         = $clog2(POS_W + 1);
  localparam int CMP_W          = 64;   // common width for position compares

  localparam int MAX_FRAME_RATE = 120;
  localparam int SECS_PER_MIN   = 60;
  localparam int FRAMES_HOUR_K  = 3600;
  localparam int FRAMES_DAY_K   = 86400;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SEEK    = 2'd1,
    MODE_DISABLE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_FRAME_RATE   = 2'd0,
    REG_START_FRAMES = 2'd1,
    REG_LENGTH_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MOD_POS,
    SEQ_MOD_START,
    SEQ_HOURS,
    SEQ_MINUTES,
    SEQ_SECONDS
  } seq_state_t;

  // Command to the shared shift-subtract divider.
  typedef struct packed {
    logic              start;
    logic [DAY_W-1:0]  rem_init;
    logic [POS_W-1:0]  dvd_init;
    logic [STEP_W-1:0] steps;
    logic [DAY_W-1:0]  divisor;
  } div_cmd_t;

  // Divider answer, valid in the cycle that done is high.
  typedef struct packed {
    logic             done;
    logic [DAY_W-1:0] rem;
    logic [6:0]       quo;
  } div_res_t;

  // Sequencer status and the fields of the last timecode.
  typedef struct packed {
    logic       busy;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] frames;
  } seq_res_t;

  // A zero rate counts as one, anything above the top rate as the top rate.
  function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] rate);
    logic [RATE_W-1:0] r;
    r = rate;
    if (r == '0) begin
      r = RATE_W'(1);
    end
    if (r > RATE_W'(MAX_FRAME_RATE)) begin
      r = RATE_W'(MAX_FRAME_RATE);
    end
    return r;
  endfunction

endpackage

@@ design/ndtc_divider.sv @@
// ============================================================================
// ndtc_divider: shared restoring divider
// Shift-subtract unit that produces one quotient bit per cycle. The caller
// preloads the partial remainder and a left-aligned dividend.
// ============================================================================
module ndtc_divider
  import ndtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_res_t res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DAY_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  dvd_r, dvd_nxt;
  logic [6:0]        quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DAY_W-1:0]  div_r, div_nxt;

  logic [DAY_W:0] trial;
  logic [DAY_W:0] diff;
  logic           fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
  end

  always_comb begin
    trial    = {rem_r, dvd_r[POS_W-1]};
    diff     = trial - {1'b0, div_r};
    fits     = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      rem_nxt  = cmd.rem_init;
      dvd_nxt  = cmd.dvd_init;
      quo_nxt  = '0;
      cnt_nxt  = cmd.steps;
      div_nxt  = cmd.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DAY_W-1:0] : trial[DAY_W-1:0];
      dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      quo_nxt = {quo_r[5:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;
  assign res.quo  = quo_r;

  // The sequencer only launches a division into an idle unit.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("divider started while busy");

  // The partial remainder always stays below the divisor while running.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  // Completion is reported exactly once, after the last step.
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && !$past(done_r))
    else $error("divider done pulse malformed");

endmodule

@@ design/ndtc_seq.sv @@
// ============================================================================
// ndtc_seq: timecode sequencer
// Drives the shared divider through the day reduction and the split into
// hours, minutes, seconds and frames.
// ============================================================================
module ndtc_seq
  import ndtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [POS_W-1:0]   position,
  input  logic [RATE_W-1:0]  frame_rate,
  input  logic [START_W-1:0] start_frames,
  output seq_res_t           res
);

  seq_state_t state_r, state_nxt;

  logic [DAY_W-1:0] pmod_r, pmod_nxt;
  logic [4:0]       hh_r, hh_nxt;
  logic [5:0]       mm_r, mm_nxt;
  logic [5:0]       ss_r, ss_nxt;
  logic [6:0]       ff_r, ff_nxt;

  div_cmd_t         cmd;
  div_res_t         dres;

  logic [RATE_W-1:0] rate;
  logic [DAY_W-1:0]  per_min;
  logic [DAY_W-1:0]  per_hour;
  logic [DAY_W-1:0]  per_day;
  logic [DAY_W:0]    sum;
  logic [DAY_W:0]    folded;
  logic [DAY_W-1:0]  count;

  ndtc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (dres)
  );

  assign rate     = eff_rate(frame_rate);
  assign per_min  = DAY_W'(rate) * DAY_W'(SECS_PER_MIN);
  assign per_hour = DAY_W'(rate) * DAY_W'(FRAMES_HOUR_K);
  assign per_day  = DAY_W'(rate) * DAY_W'(FRAMES_DAY_K);

  // Both residues are below one day, so one conditional subtract folds the sum.
  assign sum    = {1'b0, pmod_r} + {1'b0, dres.rem};
  assign folded = (sum >= {1'b0, per_day}) ? (sum - {1'b0, per_day}) : sum;
  assign count  = folded[DAY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pmod_r <= pmod_nxt;
    hh_r   <= hh_nxt;
    mm_r   <= mm_nxt;
    ss_r   <= ss_nxt;
    ff_r   <= ff_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    pmod_nxt     = pmod_r;
    hh_nxt       = hh_r;
    mm_nxt       = mm_r;
    ss_nxt       = ss_r;
    ff_nxt       = ff_r;
    cmd.start    = 1'b0;
    cmd.rem_init = '0;
    cmd.dvd_init = position;
    cmd.steps    = STEP_W'(POS_W);
    cmd.divisor  = per_day;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          cmd.start = 1'b1;
          state_nxt = SEQ_MOD_POS;
        end
      end
      SEQ_MOD_POS: begin
        if (dres.done) begin
          pmod_nxt     = dres.rem;
          cmd.start    = 1'b1;
          cmd.dvd_init = {start_frames, {(POS_W - START_W){1'b0}}};
          cmd.steps    = STEP_W'(START_W);
          state_nxt    = SEQ_MOD_START;
        end
      end
      SEQ_MOD_START: begin
        // The hour count fits in five bits, so the upper bits preload the remainder.
        if (dres.done) begin
          cmd.start    = 1'b1;
          cmd.rem_init = {5'b0, count[DAY_W-1:5]};
          cmd.dvd_init = {count[4:0], {(POS_W - 5){1'b0}}};
          cmd.steps    = STEP_W'(5);
          cmd.divisor  = per_hour;
          state_nxt    = SEQ_HOURS;
        end
      end
      SEQ_HOURS: begin
        if (dres.done) begin
          hh_nxt       = dres.quo[4:0];
          cmd.start    = 1'b1;
          cmd.rem_init = {6'b0, dres.rem[DAY_W-1:6]};
          cmd.dvd_init = {dres.rem[5:0], {(POS_W - 6){1'b0}}};
          cmd.steps    = STEP_W'(6);
          cmd.divisor  = per_min;
          state_nxt    = SEQ_MINUTES;
        end
      end
      SEQ_MINUTES: begin
        if (dres.done) begin
          mm_nxt       = dres.quo[5:0];
          cmd.start    = 1'b1;
          cmd.rem_init = {6'b0, dres.rem[DAY_W-1:6]};
          cmd.dvd_init = {dres.rem[5:0], {(POS_W - 6){1'b0}}};
          cmd.steps    = STEP_W'(6);
          cmd.divisor  = DAY_W'(rate);
          state_nxt    = SEQ_SECONDS;
        end
      end
      SEQ_SECONDS: begin
        if (dres.done) begin
          ss_nxt    = dres.quo[5:0];
          ff_nxt    = dres.rem[6:0];
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign res.busy    = (state_r != SEQ_IDLE);
  assign res.hours   = hh_r;
  assign res.minutes = mm_r;
  assign res.seconds = ss_r;
  assign res.frames  = ff_r;

  // A new timecode is only requested while the sequencer is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == SEQ_IDLE)
    else $error("sequencer started while busy");

  // Finished hours, minutes and seconds are always in their legal ranges.
  a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(res.busy) |-> hh_r < 5'd24 && mm_r < 6'd60 && ss_r < 6'd60)
    else $error("timecode field out of range");

endmodule

@@ design/non_drop_timecode_generator_top.sv @@
// ============================================================================
// non_drop_timecode_generator_top: frame-driven non-drop timecode generator
// Keeps the frame position and disabled flag, takes commands and delivers
// one status beat per command, with a timecode on accepted frame ticks.
// ============================================================================
// Each input beat is a command: frame tick, seek, disable or status query,
// and each one produces exactly one output beat. A tick that is not disabled
// and whose frame the consumer accepts carries the hours, minutes, seconds and
// frames of (start_frames + position) modulo one day of 86400 * frame_rate
// frames; otherwise those fields read zero. Status bits in every output beat
// reflect the state after the command. The block works on one command at a
// time: seeks, disables, queries and unaccepted ticks need no division, while
// a tick that needs a timecode waits on the single shift-subtract divider,
// which retires one quotient bit per cycle: 48 steps to reduce the position
// modulo one day, 24 for the start value, then 5, 6 and 6 steps for hours,
// minutes and seconds. A new command is taken as soon as the previous result
// has been moved into the output register, even if the downstream side is
// still stalling that register. Configuration registers may only be written
// while no command is in flight.
module non_drop_timecode_generator_top
  import ndtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic              in_frame_accepted,
  input  logic [SEEK_W-1:0] in_seek_position,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_timecode_valid,
  output logic [4:0]        out_hours,
  output logic [5:0]        out_minutes,
  output logic [5:0]        out_seconds,
  output logic [6:0]        out_frames,
  output logic              out_end_of_stream,
  output logic              out_is_disabled
);

  // Configuration registers.
  logic [RATE_W-1:0]  rate_r;
  logic [START_W-1:0] start_r;
  logic [LEN_W-1:0]   len_r;

  // Block state.
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               dis_r, dis_nxt;

  // Command in flight and whether its result carries a timecode.
  logic               busy_r, busy_nxt;
  logic               tcv_r, tcv_nxt;

  // Output register.
  logic               ovalid_r, ovalid_nxt;
  logic               otcv_r;
  logic [4:0]         ohh_r;
  logic [5:0]         omm_r;
  logic [5:0]         oss_r;
  logic [6:0]         off_r;
  logic               oeos_r;
  logic               odis_r;

  logic               accept;
  logic               load;
  logic               seq_start;
  logic [POS_W:0]     pos_inc;
  logic               eos;
  mode_t              mode;
  seq_res_t           sres;

  assign mode      = mode_t'(in_mode);
  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  assign seq_start = accept && (mode == MODE_TICK) && !dis_r && in_frame_accepted;

  // The timecode uses the position before this tick's advance.
  ndtc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (seq_start),
    .position     (pos_r),
    .frame_rate   (rate_r),
    .start_frames (start_r),
    .res          (sres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_W'(25);
      start_r <= '0;
      len_r   <= '1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_RATE:   rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_START_FRAMES: start_r <= cfg_wdata[START_W-1:0];
        REG_LENGTH_LIMIT: len_r   <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturating advance: the carry out marks a position already at its maximum.
  assign pos_inc = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    pos_nxt = pos_r;
    dis_nxt = dis_r;
    tcv_nxt = tcv_r;
    if (accept) begin
      tcv_nxt = 1'b0;
      case (mode)
        MODE_TICK: begin
          if (!dis_r) begin
            tcv_nxt = in_frame_accepted;
            if (!pos_inc[POS_W]) begin
              pos_nxt = pos_inc[POS_W-1:0];
            end
          end
        end
        MODE_SEEK: begin
          if (!dis_r) begin
            pos_nxt = POS_W'(in_seek_position);
          end
        end
        MODE_DISABLE: begin
          dis_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // The result moves out once the sequencer is done and the output slot frees.
  assign load = busy_r && !sres.busy && (!ovalid_r || !out_stall);
  assign eos  = !dis_r && (CMP_W'(pos_r) >= CMP_W'(len_r));

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (load) begin
      busy_nxt = 1'b0;
    end
    ovalid_nxt = ovalid_r && out_stall;
    if (load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      dis_r    <= 1'b0;
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      dis_r    <= dis_nxt;
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tcv_r <= tcv_nxt;
    if (load) begin
      otcv_r <= tcv_r;
      ohh_r  <= tcv_r ? sres.hours   : '0;
      omm_r  <= tcv_r ? sres.minutes : '0;
      oss_r  <= tcv_r ? sres.seconds : '0;
      off_r  <= tcv_r ? sres.frames  : '0;
      oeos_r <= eos;
      odis_r <= dis_r;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_timecode_valid = otcv_r;
  assign out_hours          = ohh_r;
  assign out_minutes        = omm_r;
  assign out_seconds        = oss_r;
  assign out_frames         = off_r;
  assign out_end_of_stream  = oeos_r;
  assign out_is_disabled    = odis_r;

  // A running timecode calculation always belongs to a command in flight.
  a_seq_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sres.busy |-> busy_r)
    else $error("sequencer running without a command in flight");

  // Beats without a timecode carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !otcv_r |-> ohh_r == '0 && omm_r == '0 && oss_r == '0 && off_r == '0)
    else $error("timecode fields not cleared");

  // End of stream is never reported together with the disabled flag.
  a_eos_dis: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && oeos_r |-> !odis_r)
    else $error("end of stream reported while disabled");

  // Once set, the disabled flag stays set until reset.
  a_dis_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    dis_r |=> dis_r)
    else $error("disabled flag cleared");

endmodule

@@ tb/non_drop_timecode_generator_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// non_drop_timecode_generator_top_tb: self-checking bench for the timecode block
// Drives tick, seek, disable and query beats through the valid/stall
// handshake. It predicts every status and timecode beat from its own model
// of the frame position and the disabled flag, and checks each output beat
// in order while both sides idle at random for most of the run.
// ============================================================================
module non_drop_timecode_generator_top_tb;
  import ndtc_pkg::*;

  localparam int             WATCHDOG_LIMIT = 5000;
  localparam int             HOLD_OFF_CYCLES = 400;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  // One command beat as it crosses the input handshake.
  typedef struct packed {
    mode_t             mode;
    logic              accepted;
    logic [SEEK_W-1:0] seek;
  } command_t;

  // One status beat as it leaves the block.
  typedef struct packed {
    logic       timecode_valid;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] frames;
    logic       end_of_stream;
    logic       is_disabled;
  } timecode_beat_t;

  // The ledger mirrors the registers and the stream state, and keeps the
  // status beats that the block still owes, oldest first.
  class timecode_ledger;
    logic [RATE_W-1:0]  rate_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   limit_reg;
    logic [POS_W-1:0]   position;
    logic               disabled;
    timecode_beat_t     owed[$];
    int                 failures;

    function new();
      rate_reg  = RATE_W'(25);
      start_reg = '0;
      limit_reg = '1;
      position  = '0;
      disabled  = 1'b0;
      failures  = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_FRAME_RATE: begin
          rate_reg = value[RATE_W-1:0];
        end
        REG_START_FRAMES: begin
          start_reg = value[START_W-1:0];
        end
        REG_LENGTH_LIMIT: begin
          limit_reg = value[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint unsigned rate_in_use();
      longint unsigned fps;
      fps = 64'(rate_reg);
      if (fps == 0) begin
        fps = 1;
      end
      if (fps > 64'(MAX_FRAME_RATE)) begin
        fps = 64'(MAX_FRAME_RATE);
      end
      return fps;
    endfunction

    function longint unsigned day_length();
      return 64'(FRAMES_DAY_K) * rate_in_use();
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Advances the stream state by one accepted command and queues the beat.
    function void apply_command(command_t c);
      timecode_beat_t  beat;
      longint unsigned fps, per_min, per_hour, day, count, rest;
      beat = '0;
      case (c.mode)
        MODE_TICK: begin
          if (!disabled) begin
            if (c.accepted) begin
              fps      = rate_in_use();
              per_min  = 64'(SECS_PER_MIN) * fps;
              per_hour = 64'(SECS_PER_MIN) * per_min;
              day      = 24 * per_hour;
              count    = ((64'(position) % day) + (64'(start_reg) % day)) % day;
              rest     = count % per_hour;
              beat.hours   = 5'(count / per_hour);
              beat.minutes = 6'(rest / per_min);
              rest         = rest % per_min;
              beat.seconds = 6'(rest / fps);
              beat.frames  = 7'(rest % fps);
              beat.timecode_valid = 1'b1;
            end
            if (position != POS_TOP) begin
              position = position + 1'b1;
            end
          end
        end
        MODE_SEEK: begin
          if (!disabled) begin
            position = c.seek[POS_W-1:0];
          end
        end
        MODE_DISABLE: begin
          disabled = 1'b1;
        end
        default: begin
        end
      endcase
      beat.end_of_stream = !disabled && (position >= limit_reg);
      beat.is_disabled   = disabled;
      owed.push_back(beat);
    endfunction

    function void compare_beat(timecode_beat_t got);
      timecode_beat_t want;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: output beat with nothing owed: tc=%0d %0d:%0d:%0d:%0d eos=%0d dis=%0d",
                   $realtime, got.timecode_valid, got.hours, got.minutes, got.seconds,
                   got.frames, got.end_of_stream, got.is_disabled);
        end
        return;
      end
      want = owed.pop_front();
      if (got.timecode_valid !== want.timecode_valid || got.hours !== want.hours ||
          got.minutes !== want.minutes || got.seconds !== want.seconds ||
          got.frames !== want.frames || got.end_of_stream !== want.end_of_stream ||
          got.is_disabled !== want.is_disabled) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch: expected tc=%0d %0d:%0d:%0d:%0d eos=%0d dis=%0d, got tc=%0d %0d:%0d:%0d:%0d eos=%0d dis=%0d",
                   $realtime, want.timecode_valid, want.hours, want.minutes, want.seconds,
                   want.frames, want.end_of_stream, want.is_disabled,
                   got.timecode_valid, got.hours, got.minutes, got.seconds,
                   got.frames, got.end_of_stream, got.is_disabled);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic              in_frame_accepted;
  logic [SEEK_W-1:0] in_seek_position;
  logic              out_valid;
  logic              out_stall;
  logic              out_timecode_valid;
  logic [4:0]        out_hours;
  logic [5:0]        out_minutes;
  logic [5:0]        out_seconds;
  logic [6:0]        out_frames;
  logic              out_end_of_stream;
  logic              out_is_disabled;

  timecode_ledger ledger;
  timecode_beat_t seen_beat;

  // Idling switches for each side, and the long hold-off requests: the main
  // sequence raises holds_asked and the receiver answers in its own process.
  bit in_idle_on;
  bit out_idle_on;
  int holds_asked;
  int holds_served;

  non_drop_timecode_generator_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_frame_accepted  (in_frame_accepted),
    .in_seek_position   (in_seek_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_timecode_valid (out_timecode_valid),
    .out_hours          (out_hours),
    .out_minutes        (out_minutes),
    .out_seconds        (out_seconds),
    .out_frames         (out_frames),
    .out_end_of_stream  (out_end_of_stream),
    .out_is_disabled    (out_is_disabled)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Output monitor. Outputs are read in the active region of the rising
  // edge, so they still hold the values that the edge itself samples.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_beat.timecode_valid = out_timecode_valid;
      seen_beat.hours          = out_hours;
      seen_beat.minutes        = out_minutes;
      seen_beat.seconds        = out_seconds;
      seen_beat.frames         = out_frames;
      seen_beat.end_of_stream  = out_end_of_stream;
      seen_beat.is_disabled    = out_is_disabled;
      ledger.compare_beat(seen_beat);
    end
  end

  // Receiver. It stalls in short random bursts while out_idle_on is set, and
  // serves a long hold-off whenever one is requested. During a hold-off the
  // sender keeps offering beats, so the block fills and stalls its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        holds_served++;
      end else if (out_idle_on && $urandom_range(0, 99) < 10) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no beat has moved on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no handshake progress, giving up", $realtime);
    $display("non_drop_timecode_generator_top_tb: FAIL");
    $finish;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic command_t make_cmd(mode_t mode, logic accepted, logic [SEEK_W-1:0] seek);
    command_t c;
    c.mode     = mode;
    c.accepted = accepted;
    c.seek     = seek;
    return c;
  endfunction

  // Seek targets lean toward the interesting spots: day boundaries, the
  // saturation point, and both sides of the end-of-stream limit.
  function automatic logic [SEEK_W-1:0] pick_seek();
    longint          near;
    longint unsigned far;
    logic [SEEK_W-1:0] pos;
    case ($urandom_range(0, 5))
      0: begin
        pos = rand48();
      end
      1: begin
        pos = 48'($urandom % 32'(3 * ledger.day_length()));
      end
      2: begin
        pos = POS_TOP - 48'($urandom_range(0, 4));
      end
      3: begin
        near = longint'({16'd0, ledger.limit_reg}) + longint'($urandom_range(0, 6)) - 64'sd3;
        if (near < 0) begin
          near = 0;
        end
        if (near > longint'({16'd0, POS_TOP})) begin
          near = longint'({16'd0, POS_TOP});
        end
        pos = near[SEEK_W-1:0];
      end
      4: begin
        far = ledger.day_length() * longint'($urandom_range(1, 40)) - $urandom_range(0, 3);
        pos = far[SEEK_W-1:0];
      end
      default: begin
        pos = rand48() >> $urandom_range(0, 47);
      end
    endcase
    return pos;
  endfunction

  // Mostly accepted ticks, so that timecodes keep flowing, with seeks,
  // queries and dropped frames mixed in. Unused fields carry random bits.
  function automatic command_t random_command(bit allow_disable);
    command_t c;
    int       pick;
    c.accepted = 1'($urandom_range(0, 1));
    c.seek     = rand48();
    pick = $urandom_range(0, 99);
    if (allow_disable && pick < 8) begin
      c.mode = MODE_DISABLE;
    end else if (pick < 70) begin
      c.mode     = MODE_TICK;
      c.accepted = ($urandom_range(0, 99) < 85);
    end else if (pick < 86) begin
      c.mode = MODE_SEEK;
      c.seek = pick_seek();
    end else if (pick < 94) begin
      c.mode = MODE_QUERY;
    end else begin
      c.mode     = MODE_TICK;
      c.accepted = 1'b0;
    end
    return c;
  endfunction

  // Offers one beat and returns just after the falling edge that follows
  // its acceptance, with valid still high so that back-to-back beats flow.
  task automatic send_beat(command_t c);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 99) < 10) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_mode           = c.mode;
    in_frame_accepted = c.accepted;
    in_seek_position  = c.seek;
    do @(posedge clk); while (in_stall);
    ledger.apply_command(c);
    @(negedge clk);
  endtask

  // Waits until every owed beat has come out, then waits on with the input quiet.
  task automatic settle();
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_registers(logic [RATE_W-1:0] rate, logic [START_W-1:0] start,
                                   logic [LEN_W-1:0] limit);
    cfg_we    = 1'b1;
    cfg_index = REG_FRAME_RATE;
    cfg_wdata = CFG_W'(rate);
    @(negedge clk);
    cfg_index = REG_START_FRAMES;
    cfg_wdata = CFG_W'(start);
    @(negedge clk);
    cfg_index = REG_LENGTH_LIMIT;
    cfg_wdata = CFG_W'(limit);
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.set_register(REG_FRAME_RATE, CFG_W'(rate));
    ledger.set_register(REG_START_FRAMES, CFG_W'(start));
    ledger.set_register(REG_LENGTH_LIMIT, CFG_W'(limit));
  endtask

  // One random phase under one register setting. Idling on each side is
  // redrawn every 64 beats, which leaves stretches with none at all.
  task automatic run_phase(logic [RATE_W-1:0] rate, logic [START_W-1:0] start,
                           logic [LEN_W-1:0] limit, int count, bit hold_off);
    settle();
    program_registers(rate, start, limit);
    if (hold_off) begin
      holds_asked++;
    end
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_beat(random_command(1'b0));
    end
    in_valid = 1'b0;
  endtask

  // Directed beats under the reset settings: the first frames, a dropped
  // frame, the wrap at the end of the day, saturation at the top position,
  // and garbage in fields that a command does not use.
  task automatic directed_checks();
    send_beat(make_cmd(MODE_QUERY, 1'b0, '0));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 1'b0, '1));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b0, 48'd2159999));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b1, POS_TOP));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b0, POS_TOP - 1'b1));
    send_beat(make_cmd(MODE_TICK, 1'b0, '0));
    send_beat(make_cmd(MODE_QUERY, 1'b0, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b0, 48'd90000));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b1, 48'hAAAA_AAAA_AAAA));
    send_beat(make_cmd(MODE_TICK, 1'b1, 48'h5555_5555_5555));
    send_beat(make_cmd(MODE_SEEK, 1'b0, 48'h5555_5555_5555));
    send_beat(make_cmd(MODE_QUERY, 1'b1, '1));
    send_beat(make_cmd(MODE_TICK, 1'b1, '1));
    in_valid = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_FRAME_RATE;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_mode           = MODE_QUERY;
    in_frame_accepted = 1'b0;
    in_seek_position  = '0;
    in_idle_on        = 1'b1;
    out_idle_on       = 1'b1;
    holds_asked       = 0;
    holds_served      = 0;
    ledger            = new();

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_checks();

    // Register extremes: slowest rate with end of stream from position zero,
    // top rate with the last start of the day, a zero rate, a start past one
    // day, a rate above the top, and a few random settings.
    run_phase(RATE_W'(1), START_W'(0), LEN_W'(0), 220, 1'b0);
    run_phase(RATE_W'(120), START_W'(10367999), LEN_W'(1000), 220, 1'b1);
    run_phase(RATE_W'(0), 24'hFF_FFFF, LEN_W'(5000), 220, 1'b0);
    run_phase(RATE_W'(127), START_W'(12345), 48'h8000_0000_0000, 220, 1'b0);
    run_phase(RATE_W'(30), START_W'(5000000), '1, 220, 1'b1);
    run_phase(RATE_W'($urandom_range(1, 120)), START_W'($urandom_range(0, 10367999)),
              LEN_W'($urandom_range(0, 5000)), 220, 1'b0);
    run_phase(RATE_W'(24), START_W'($urandom), rand48(), 200, 1'b0);

    // Last part, no idling: ticks up to the end-of-stream limit, the disable,
    // the commands it makes inert, a second disable, then random beats of all kinds.
    settle();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    program_registers(RATE_W'(60), START_W'(1000), LEN_W'(50));
    send_beat(make_cmd(MODE_SEEK, 1'b0, 48'd48));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_QUERY, 1'b0, '0));
    send_beat(make_cmd(MODE_DISABLE, 1'b1, '1));
    send_beat(make_cmd(MODE_TICK, 1'b1, '0));
    send_beat(make_cmd(MODE_TICK, 1'b0, '0));
    send_beat(make_cmd(MODE_SEEK, 1'b0, 48'd7));
    send_beat(make_cmd(MODE_QUERY, 1'b0, '0));
    send_beat(make_cmd(MODE_DISABLE, 1'b0, '0));
    for (int i = 0; i < 60; i++) begin
      send_beat(random_command(1'b1));
    end
    in_valid = 1'b0;

    // Drain, then leave time for any stray beat to show up.
    while (ledger.pending() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("non_drop_timecode_generator_top_tb: PASS");
    end else begin
      $display("non_drop_timecode_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ndtc_pkg.sv
design/ndtc_divider.sv
design/ndtc_seq.sv
design/non_drop_timecode_generator_top.sv
tb/non_drop_timecode_generator_top_tb.sv
